// ===== sv/pls_pkg.sv =====
// Shared types for the positional list store.
// Request codes, status codes and the decoded command that drives the cell chain.
package pls_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } dec_t;

endpackage

// ===== sv/pls_ctrl.sv =====
// Request decoder: checks a request against the fill count and picks the slot.
// Depends on pls_pkg.
module pls_ctrl import pls_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic [2:0]                      req_type,
  input  logic [4:0]                      position,
  input  logic [$clog2(CAPACITY+1)-1:0]   count,
  output dec_t                            dec,
  output logic [$clog2(CAPACITY)-1:0]     slot
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int WW = ((CW > 5) ? CW : 5) + 1;

  logic [WW-1:0] pos_w;
  logic [WW-1:0] cnt_w;
  logic          full;
  logic          empty;
  logic          ins_pos_ok;
  logic          del_pos_ok;

  assign pos_w      = WW'(position);
  assign cnt_w      = WW'(count);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
  assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    dec.op     = OP_NONE;
    dec.status = ST_OK;
    slot       = '0;
    case (req_t'(req_type))
      REQ_ADD_FRONT: begin
        if (full) dec.status = ST_FULL;
        else      dec.op     = OP_INS;
      end
      REQ_ADD_END: begin
        slot = AW'(count);
        if (full) dec.status = ST_FULL;
        else      dec.op     = OP_INS;
      end
      REQ_INS_POS: begin
        slot = AW'(pos_w - WW'(1));
        if (full)             dec.status = ST_FULL;
        else if (!ins_pos_ok) dec.status = ST_BADPOS;
        else                  dec.op     = OP_INS;
      end
      REQ_DEL_FRONT: begin
        if (empty) dec.status = ST_EMPTY;
        else       dec.op     = OP_DEL;
      end
      REQ_DEL_END: begin
        slot = AW'(count - CW'(1));
        if (empty) dec.status = ST_EMPTY;
        else       dec.op     = OP_DEL;
      end
      REQ_DEL_POS: begin
        slot = AW'(pos_w - WW'(1));
        if (empty)            dec.status = ST_EMPTY;
        else if (!del_pos_ok) dec.status = ST_BADPOS;
        else                  dec.op     = OP_DEL;
      end
      default: begin
        dec.op     = OP_NONE;
        dec.status = ST_OK;
      end
    endcase
  end

endmodule

// ===== sv/pls_cell.sv =====
// One storage cell of the list chain: holds one entry, loads a new word or a neighbor's.
// Depends on pls_pkg.
module pls_cell import pls_pkg::*; #(
  parameter int IDX = 0,
  parameter int AW  = 4
) (
  input  logic               clk,
  input  op_t                op,
  input  logic [AW-1:0]      slot,
  input  logic signed [31:0] wr_value,
  input  logic signed [31:0] left_value,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] q
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      OP_INS: begin
        if (MY_IDX == slot)     data_nxt = wr_value;
        else if (MY_IDX > slot) data_nxt = left_value;
      end
      OP_DEL: begin
        if (MY_IDX >= slot) data_nxt = right_value;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== sv/positional_list_store_top.sv =====
// Positional list store: one request per cycle unless stalled, result the cycle after.
// CAPACITY cells shift the entries from the slot onward together on insert or delete.
// Throughput is one word per cycle while the result side takes words.
// Reset clears the fill count, front/back values and the result valid; cell contents
// are left as they are and are never read before being written.
module positional_list_store_top import pls_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]         out_entry_count,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic signed [31:0] cell_q [CAPACITY];

  logic [CW-1:0]      count_r, count_nxt;
  logic signed [31:0] front_r, front_nxt;
  logic signed [31:0] back_r, back_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic signed [31:0] removed_r, removed_nxt;

  dec_t               dec;
  logic [AW-1:0]      slot;
  logic               in_acc;
  op_t                cell_op;
  logic [AW-1:0]      last_idx;
  logic               at_last;
  logic [AW-1:0]      rd_idx;
  logic signed [31:0] rd_value;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  pls_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .req_type (in_req_type),
    .position (in_position),
    .count    (count_r),
    .dec      (dec),
    .slot     (slot)
  );

  assign cell_op  = in_acc ? dec.op : OP_NONE;
  assign last_idx = AW'(count_r - CW'(1));
  assign at_last  = (slot == last_idx);
  assign rd_idx   = at_last ? AW'(count_r - CW'(2)) : slot;
  assign rd_value = cell_q[rd_idx];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = in_value;
    end else begin : g_mid
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = cell_q[i];
    end else begin : g_inner
      assign right_v = cell_q[i+1];
    end
    pls_cell #(.IDX(i), .AW(AW)) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .slot        (slot),
      .wr_value    (in_value),
      .left_value  (left_v),
      .right_value (right_v),
      .q           (cell_q[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = dec.status;
      removed_nxt   = '0;
      case (dec.op)
        OP_INS: begin
          count_nxt = count_r + CW'(1);
          if (slot == '0) front_nxt = in_value;
          if (slot == AW'(count_r)) back_nxt = in_value;
        end
        OP_DEL: begin
          count_nxt   = count_r - CW'(1);
          removed_nxt = at_last ? back_r : rd_value;
          if (count_r == CW'(1)) begin
            front_nxt = '0;
            back_nxt  = '0;
          end else begin
            if (slot == '0) front_nxt = cell_q[1];
            if (at_last) back_nxt = rd_value;
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = 5'(count_r);
  assign out_front_value   = front_r;
  assign out_back_value    = back_r;

endmodule
